/* hw/rtl/hrd_pkg.sv */
// History record deframer package: payload structs, parse phases, disposition
// codes and register indexes shared by the deframer and its classifier.
// No dependencies.
`default_nettype none

package hrd_pkg;

   localparam logic [7:0] MARK_BYTE = 8'hFF;
   localparam int unsigned CSR_IDX_W = 2;
   localparam int unsigned CSR_DATA_W = 31;
   localparam logic [CSR_IDX_W-1:0] CSR_HISTORY_SIZE = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_START_LINE = 2'd1;
   localparam logic [10:0] HIST_SIZE_RESET = 11'd128;

   typedef enum logic [2:0] {
      PH_HDR  = 3'd0,
      PH_N1   = 3'd1,
      PH_N2   = 3'd2,
      PH_N3   = 3'd3,
      PH_N4   = 3'd4,
      PH_BODY = 3'd5
   } phase_type;

   typedef enum logic [1:0] {
      DISP_APPEND  = 2'd0,
      DISP_REPLACE = 2'd1,
      DISP_DROPPED = 2'd2
   } disp_type;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       last_byte;
   } req_type;

   typedef struct packed {
      logic [7:0]         payload_byte;
      logic signed [31:0] record_number;
      logic               end_of_record;
      logic [1:0]         disposition;
      logic [9:0]         slot_from_newest;
      logic [10:0]        entries_held;
   } rsp_type;

   typedef struct packed {
      logic       append;
      disp_type   disposition;
      logic [9:0] slot_from_newest;
   } cls_type;

endpackage

`default_nettype wire

/* hw/rtl/hrd_classify.sv */
// Record classifier: decides append, replace or drop for a finished record.
// Depends on hrd_pkg.
`default_nettype none

module hrd_classify
   import hrd_pkg::*;
(
   input  wire logic [31:0] record_number,
   input  wire logic [31:0] current_line,
   input  wire logic [10:0] held_count,
   output cls_type          cls
);

   logic [32:0] diff;
   logic        next_line;
   logic        in_window;

   always_comb begin
      diff      = {current_line[31], current_line} - {record_number[31], record_number};
      next_line = (record_number - 32'd1) == current_line;
      in_window = !diff[32] && (diff[31:0] < 32'(held_count));
      cls       = '0;
      if (held_count == 11'd0 || next_line) begin
         cls.append      = 1'b1;
         cls.disposition = DISP_APPEND;
      end else if (in_window) begin
         cls.disposition      = DISP_REPLACE;
         cls.slot_from_newest = diff[9:0];
      end else begin
         cls.disposition = DISP_DROPPED;
      end
   end

endmodule

`default_nettype wire

/* hw/rtl/history_record_deframer.sv */
// History record deframer top level: byte parser, line and count state,
// result register. Depends on hrd_pkg and hrd_classify.
//
//   Port group   Dir   Handshake            Carries
//   req_*        in    req_valid/req_ready  req_type: data_byte, last_byte
//   rsp_*        out   rsp_valid/rsp_ready  rsp_type: one result per payload byte
//   csr_*        in    csr_we               csr_index, csr_wdata (31 bits)
//
// One byte per cycle while req_ready is high; a result appears in rsp in the cycle after its transfer.
// The parser and the classifier sit between req and the result register.
// req_ready is high while the result register is empty or being drained.
// Reset: header search, line 0, no entries held, history size 128.
`default_nettype none

module history_record_deframer
   import hrd_pkg::*;
#(
   parameter int unsigned MAX_ENTRIES = 1024
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_ready,
   input  req_type                    req_data,
   output logic                       rsp_valid,
   input  wire logic                  rsp_ready,
   output rsp_type                    rsp_data,
   input  wire logic                  csr_we,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam int unsigned HeldMax = (MAX_ENTRIES < 2047) ? MAX_ENTRIES : 2047;
   localparam int unsigned HW = $clog2(HeldMax + 1);
   localparam logic [10:0] SizeCap = 11'(HeldMax);

   phase_type   phase_ff, phase_in;
   logic [31:0] num_ff, num_in;
   logic [31:0] line_ff, line_in;
   logic [HW-1:0] held_ff, held_in;
   logic [10:0] hist_size_ff;
   logic        rsp_valid_ff;
   rsp_type     rsp_data_ff;
   logic        res_valid;
   rsp_type     res_data;
   logic        req_fire;
   logic        is_nul;
   logic [10:0] eff_size;
   logic [10:0] held_ext;
   cls_type     cls;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign req_fire  = req_valid && req_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;
   assign is_nul    = req_data.data_byte == 8'd0;
   assign held_ext  = 11'(held_ff);

   always_comb begin
      if (hist_size_ff == 11'd0) begin
         eff_size = 11'd1;
      end else if (hist_size_ff > SizeCap) begin
         eff_size = SizeCap;
      end else begin
         eff_size = hist_size_ff;
      end
   end

   hrd_classify u_classify (
      .record_number(num_ff),
      .current_line (line_ff),
      .held_count   (held_ext),
      .cls          (cls)
   );

   // next parse phase
   always_comb begin
      phase_in = phase_ff;
      if (req_fire) begin
         unique case (phase_ff)
            PH_HDR:  if (req_data.data_byte == MARK_BYTE) phase_in = PH_N1;
            PH_N1:   phase_in = PH_N2;
            PH_N2:   phase_in = PH_N3;
            PH_N3:   phase_in = PH_N4;
            PH_N4:   phase_in = PH_BODY;
            PH_BODY: if (is_nul) phase_in = PH_HDR;
            default: phase_in = PH_HDR;
         endcase
         if (req_data.last_byte) begin
            phase_in = PH_HDR;
         end
      end
   end

   // result and state updates
   always_comb begin
      res_valid = 1'b0;
      res_data  = '0;
      num_in    = num_ff;
      line_in   = line_ff;
      held_in   = held_ff;
      if (req_fire) begin
         unique case (phase_ff)
            PH_N1:   num_in = {req_data.data_byte, 24'd0};
            PH_N2:   num_in = num_ff | {8'd0, req_data.data_byte, 16'd0};
            PH_N3:   num_in = num_ff | {16'd0, req_data.data_byte, 8'd0};
            PH_N4:   num_in = num_ff | {24'd0, req_data.data_byte};
            PH_BODY: begin
               res_valid              = 1'b1;
               res_data.payload_byte  = req_data.data_byte;
               res_data.record_number = num_ff;
               if (is_nul) begin
                  res_data.end_of_record    = 1'b1;
                  res_data.disposition      = cls.disposition;
                  res_data.slot_from_newest = cls.slot_from_newest;
                  if (cls.append) begin
                     line_in = num_ff;
                     if (held_ext >= eff_size) begin
                        held_in = HW'(eff_size);
                     end else begin
                        held_in = held_ff + HW'(1);
                     end
                  end
               end
            end
            default: ;
         endcase
      end
      res_data.entries_held = 11'(held_in);
      if (csr_we && csr_index == CSR_START_LINE) begin
         line_in = {1'b0, csr_wdata};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_HDR;
         num_ff       <= '0;
         line_ff      <= '0;
         held_ff      <= '0;
         hist_size_ff <= HIST_SIZE_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         num_ff   <= num_in;
         line_ff  <= line_in;
         held_ff  <= held_in;
         if (csr_we && csr_index == CSR_HISTORY_SIZE) begin
            hist_size_ff <= csr_wdata[10:0];
         end
         if (req_ready) begin
            rsp_valid_ff <= res_valid;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_ready) begin
         rsp_data_ff <= res_data;
      end
   end

   a_held_bound: assert property (@(posedge clock) disable iff (reset)
      32'(held_ff) <= HeldMax)
      else $error("held count above capacity");

   a_body_gives_result: assert property (@(posedge clock) disable iff (reset)
      req_fire && phase_ff == PH_BODY |=> rsp_valid_ff)
      else $error("payload transfer without result");

   a_eor_to_hdr: assert property (@(posedge clock) disable iff (reset)
      req_fire && phase_ff == PH_BODY && is_nul |=> phase_ff == PH_HDR)
      else $error("parser not back in header search after terminator");

   a_append_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_data_ff.end_of_record
         && rsp_data_ff.disposition == DISP_APPEND |-> rsp_data_ff.entries_held != 11'd0)
      else $error("append left store empty");

endmodule

`default_nettype wire

/* tb/hrd_result_checker.sv */
// Result checker for history_record_deframer: follows req, rsp and csr
// transfers, predicts each result in order and compares it field by field.
// Depends on hrd_pkg.
module hrd_result_checker
   import hrd_pkg::*;
#(
   parameter int unsigned MAX_ENTRIES = 1024
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   input  wire logic                  req_ready,
   input  req_type                    req_data,
   input  wire logic                  rsp_valid,
   input  wire logic                  rsp_ready,
   input  rsp_type                    rsp_data,
   input  wire logic                  csr_we,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_wdata,
   output int                         mismatch_count,
   output int                         results_due,
   output logic [31:0]                line_now,
   output logic [10:0]                held_now
);
   timeunit 1ns;
   timeprecision 1ps;

   phase_type   phase;
   logic [31:0] number_acc;
   logic [31:0] cur_line;
   logic [10:0] held;
   logic [10:0] size_reg;
   rsp_type     due_q [$];

   assign line_now = cur_line;
   assign held_now = held;

   function automatic logic [10:0] size_limit();
      if (size_reg == 11'd0) return 11'd1;
      if (size_reg > MAX_ENTRIES) return 11'(MAX_ENTRIES);
      return size_reg;
   endfunction

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      mismatch_count++;
      if (mismatch_count <= 40)
         $display("%0t: rsp %s: got %h, want %h", $time, what, got, want);
   endtask

   task automatic predict_transfer(input req_type item);
      rsp_type r;
      longint  line_gap;
      r = '0;
      case (phase)
         PH_HDR: if (item.data_byte == MARK_BYTE) phase = PH_N1;
         PH_N1: begin
            number_acc = {item.data_byte, 24'd0};
            phase = PH_N2;
         end
         PH_N2: begin
            number_acc[23:16] = item.data_byte;
            phase = PH_N3;
         end
         PH_N3: begin
            number_acc[15:8] = item.data_byte;
            phase = PH_N4;
         end
         PH_N4: begin
            number_acc[7:0] = item.data_byte;
            phase = PH_BODY;
         end
         default: begin
            r.payload_byte = item.data_byte;
            r.record_number = number_acc;
            if (item.data_byte == 8'd0) begin
               r.end_of_record = 1'b1;
               line_gap = longint'($signed(cur_line)) - longint'($signed(number_acc));
               if (held == 11'd0 || number_acc - 32'd1 == cur_line) begin
                  r.disposition = DISP_APPEND;
                  cur_line = number_acc;
                  if (held >= size_limit()) held = size_limit();
                  else held = held + 11'd1;
               end else if (line_gap >= 0 && line_gap < longint'(held)) begin
                  r.disposition = DISP_REPLACE;
                  r.slot_from_newest = line_gap[9:0];
               end else begin
                  r.disposition = DISP_DROPPED;
               end
               phase = PH_HDR;
            end
            r.entries_held = held;
            due_q.push_back(r);
         end
      endcase
      if (item.last_byte) phase = PH_HDR;
   endtask

   task automatic compare_result(input rsp_type got);
      rsp_type want;
      if (due_q.size() == 0) begin
         report_mismatch("transfer with no result due", got.record_number, '0);
      end else begin
         want = due_q.pop_front();
         if (got.payload_byte !== want.payload_byte)
            report_mismatch("payload_byte", 32'(got.payload_byte),
                            32'(want.payload_byte));
         if (got.record_number !== want.record_number)
            report_mismatch("record_number", got.record_number, want.record_number);
         if (got.end_of_record !== want.end_of_record)
            report_mismatch("end_of_record", 32'(got.end_of_record),
                            32'(want.end_of_record));
         if (got.disposition !== want.disposition)
            report_mismatch("disposition", 32'(got.disposition),
                            32'(want.disposition));
         if (got.slot_from_newest !== want.slot_from_newest)
            report_mismatch("slot_from_newest", 32'(got.slot_from_newest),
                            32'(want.slot_from_newest));
         if (got.entries_held !== want.entries_held)
            report_mismatch("entries_held", 32'(got.entries_held),
                            32'(want.entries_held));
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         phase = PH_HDR;
         number_acc = '0;
         cur_line = '0;
         held = '0;
         size_reg = HIST_SIZE_RESET;
         due_q.delete();
         mismatch_count = 0;
      end else begin
         if (rsp_valid && rsp_ready) compare_result(rsp_data);
         if (csr_we) begin
            if (csr_index == CSR_HISTORY_SIZE) size_reg = csr_wdata[10:0];
            else if (csr_index == CSR_START_LINE) cur_line = {1'b0, csr_wdata};
         end
         if (req_valid && req_ready) predict_transfer(req_data);
      end
      results_due = due_q.size();
   end

endmodule

/* tb/tb_history_record_deframer.sv */
// Testbench top for history_record_deframer: clock, reset, record stimulus,
// register phases and the verdict. Depends on hrd_pkg, the DUT and hrd_result_checker.
module tb_history_record_deframer;
   import hrd_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned MAX_ENTRIES = 1024;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int NO_CUT = -1;
   localparam int RANDOM_FILL = -1;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_A = CSR_START_LINE + 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_B = CSR_START_LINE + 2'd2;

   logic                  clock;
   logic                  reset;
   logic                  req_valid;
   logic                  req_ready;
   req_type               req_data;
   logic                  rsp_valid;
   logic                  rsp_ready;
   rsp_type               rsp_data;
   logic                  csr_we;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;
   int                    mismatch_count;
   int                    results_due;
   logic [31:0]           line_now;
   logic [10:0]           held_now;
   bit                    calm;
   int                    record_bytes;

   history_record_deframer #(
      .MAX_ENTRIES(MAX_ENTRIES)
   ) u_dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data(rsp_data),
      .csr_we(csr_we),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   hrd_result_checker #(
      .MAX_ENTRIES(MAX_ENTRIES)
   ) u_checker (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data(rsp_data),
      .csr_we(csr_we),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata),
      .mismatch_count(mismatch_count),
      .results_due(results_due),
      .line_now(line_now),
      .held_now(held_now)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   function automatic int idle_len();
      int pick;
      if (calm) return 0;
      pick = $urandom_range(0, 99);
      if (pick < 60) return 0;
      if (pick < 92) return $urandom_range(1, 3);
      return $urandom_range(4, 20);
   endfunction

   task automatic send_byte(input logic [7:0] value, input logic last);
      int gap;
      gap = idle_len();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_data <= {value, last};
      req_valid <= 1'b1;
      do @(posedge clock); while (!(req_valid && req_ready));
      @(negedge clock);
   endtask

   task automatic send_record(input logic [31:0] num, input int len, input int cut,
                              input int fill);
      logic [7:0] value;
      int         stop;
      stop = (cut >= 0 && cut < len + 5) ? cut : len + 5;
      for (int i = 0; i <= stop; i++) begin
         if (i == 0) value = MARK_BYTE;
         else if (i <= 4) value = num[8*(4-i) +: 8];
         else if (i == len + 5) value = 8'd0;
         else if (fill >= 0) value = 8'(fill);
         else if ($urandom_range(0, 7) == 0) value = MARK_BYTE;
         else value = 8'($urandom_range(1, 254));
         send_byte(value, i == cut);
         record_bytes++;
      end
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      @(negedge clock);
      while (results_due != 0) @(negedge clock);
   endtask

   task automatic settle();
      drain();
      repeat (4) @(negedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] data);
      csr_index <= idx;
      csr_wdata <= data;
      csr_we <= 1'b1;
      @(negedge clock);
      csr_we <= 1'b0;
      @(negedge clock);
   endtask

   function automatic logic [31:0] pick_number();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 45) return line_now + 32'd1;
      if (pick < 70 && held_now != 11'd0)
         return line_now - 32'($urandom_range(0, held_now - 11'd1));
      if (pick < 80) return line_now - 32'(held_now);
      if (pick < 85) return line_now + 32'd2;
      if (pick < 95) return $urandom;
      case ($urandom_range(0, 3))
         0: return 32'h0000_0000;
         1: return 32'hFFFF_FFFF;
         2: return 32'h8000_0000;
         default: return 32'h7FFF_FFFF;
      endcase
   endfunction

   task automatic run_random(input int budget);
      int pick;
      int len;
      int cut;
      int goal;
      goal = record_bytes + budget;
      while (record_bytes < goal) begin
         if ($urandom_range(0, 49) == 0) calm = ~calm;
         if ($urandom_range(0, 149) == 0) drain();
         pick = $urandom_range(0, 99);
         if (pick < 8) begin
            repeat ($urandom_range(1, 4))
               send_byte(8'($urandom_range(0, 254)), $urandom_range(0, 9) == 0);
         end else begin
            pick = $urandom_range(0, 99);
            len = pick < 70 ? $urandom_range(0, 3) :
                  pick < 95 ? $urandom_range(4, 8) : $urandom_range(9, 16);
            cut = $urandom_range(0, 99) < 10 ? $urandom_range(0, len + 5) : NO_CUT;
            send_record(pick_number(), len, cut, RANDOM_FILL);
         end
      end
   endtask

   // stall the result side in random stretches
   initial begin
      int stall;
      stall = 0;
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            stall--;
         end else begin
            rsp_ready <= 1'b1;
            stall = idle_len();
         end
      end
   end

   initial begin
      int idle_cycles;
      idle_cycles = 0;
      while (idle_cycles < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) idle_cycles = 0;
         else idle_cycles++;
      end
      $display("Some tests failed");
      $finish;
   end

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      csr_we = 1'b0;
      csr_index = CSR_HISTORY_SIZE;
      csr_wdata = '0;
      calm = 1'b0;
      record_bytes = 0;
      repeat (3) @(negedge clock);
      reset <= 1'b0;

      send_record(32'd5, 0, NO_CUT, RANDOM_FILL);
      send_record(32'd6, 1, NO_CUT, MARK_BYTE);
      send_record(32'd5, 0, NO_CUT, RANDOM_FILL);
      // drop on a far number, final byte on the terminator
      send_record(32'h8000_0000, 0, 5, RANDOM_FILL);
      // cut short in the payload
      send_record(32'hFFFF_FFFF, 1, 5, 8'h7F);

      for (int p = 0; p < 6; p++) begin
         settle();
         case (p)
            0: begin
               write_reg(CSR_SPARE_A, '1);
               write_reg(CSR_SPARE_B, 31'h15A5_A5A5);
               write_reg(CSR_HISTORY_SIZE, 31'd1);
               write_reg(CSR_START_LINE, 31'd100);
            end
            1: begin
               write_reg(CSR_HISTORY_SIZE, 31'd0);
               write_reg(CSR_START_LINE, 31'h7FFF_FFFF);
            end
            2: begin
               write_reg(CSR_HISTORY_SIZE, 31'd1024);
               write_reg(CSR_START_LINE, 31'd0);
            end
            3: begin
               write_reg(CSR_HISTORY_SIZE, 31'd2047);
               write_reg(CSR_START_LINE, 31'd1000);
            end
            4: begin
               write_reg(CSR_HISTORY_SIZE, 31'd5);
               write_reg(CSR_START_LINE, 31'h0000_FFFF);
            end
            default: begin
               write_reg(CSR_HISTORY_SIZE, 31'($urandom_range(2, 40)));
               write_reg(CSR_START_LINE, 31'($urandom));
            end
         endcase
         run_random(170);
      end

      settle();
      if (mismatch_count == 0 && results_due == 0) $display("All tests passed");
      else $display("Some tests failed");
      $finish;
   end

endmodule
